@@ rtl/core/wse_pkg.sv @@
`timescale 1ns / 1ps

package wse_pkg;

    // grid and sample sizes
    localparam int MAX_POINTS  = 64;
    localparam int MIN_POINTS  = 3;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int ALPHA_W     = 16;
    localparam int CFG_DATA_W  = 16;

    // fixed-point layout: alpha is Q0.16, start formula is scaled by one more bit
    localparam int FRAC_LF = ALPHA_W;
    localparam int FRAC_ST = ALPHA_W + 1;

    // datapath widths
    localparam int DIFF_W = SAMPLE_BITS + 3;
    localparam int PROD_W = ALPHA_W + 1 + DIFF_W;
    localparam int NUM_W  = PROD_W + 2;

    // stream packing
    localparam int TDATA_W = 8 * ((IDX_W + SAMPLE_BITS + 7) / 8);

    // register map
    localparam logic CFG_ALPHA_SQ      = 1'b0;
    localparam logic CFG_ACTIVE_POINTS = 1'b1;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET  = ALPHA_W'(16384);
    localparam logic [CNT_W-1:0]   POINTS_RESET = CNT_W'(MAX_POINTS);

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic        [IDX_W-1:0]       idx_t;
    typedef logic        [CNT_W-1:0]       cnt_t;
    typedef logic        [ALPHA_W-1:0]     alpha_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [NUM_W-1:0]       num_t;

    typedef struct packed {
        sample_t cur;
        sample_t prev;
    } cell_data_t;

    typedef struct packed {
        logic load;   // write a loaded sample into cur
        logic shift;  // take the neighbor's pair this cycle
        logic tail;   // last active cell, closes the ring
        logic age;    // inactive cell: prev takes cur
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } state_t;

endpackage

@@ rtl/core/wse_cell.sv @@
`timescale 1ns / 1ps

module wse_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  wse_pkg::cell_ctrl_t ctrl,
    input  wse_pkg::sample_t    load_val,
    input  wse_pkg::cell_data_t nb_in,
    input  wse_pkg::cell_data_t tail_in,
    output wse_pkg::cell_data_t q,
    output wse_pkg::sample_t    tap
);

    wse_pkg::sample_t cur_reg, cur_next;
    wse_pkg::sample_t prev_reg, prev_next;

    always_comb begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        if (ctrl.load) begin
            cur_next = load_val;
        end else if (ctrl.shift) begin
            if (ctrl.tail) begin
                // new value enters with the old value of its point as prev
                cur_next  = tail_in.cur;
                prev_next = tail_in.prev;
            end else begin
                cur_next  = nb_in.cur;
                prev_next = nb_in.prev;
            end
        end else if (ctrl.age) begin
            prev_next = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else begin
            cur_reg <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
    end

    assign q.cur  = cur_reg;
    assign q.prev = prev_reg;
    assign tap    = ctrl.tail ? cur_reg : '0;

endmodule

@@ rtl/core/wse_update.sv @@
`timescale 1ns / 1ps

module wse_update (
    input  wse_pkg::alpha_t  alpha_sq,
    input  logic             started,
    input  wse_pkg::sample_t left,
    input  wse_pkg::sample_t centre,
    input  wse_pkg::sample_t right,
    input  wse_pkg::sample_t prev,
    output wse_pkg::sample_t result
);

    localparam wse_pkg::num_t HALF_LF = wse_pkg::num_t'(1) <<< (wse_pkg::FRAC_LF - 1);
    localparam wse_pkg::num_t HALF_ST = wse_pkg::num_t'(1) <<< (wse_pkg::FRAC_ST - 1);
    localparam wse_pkg::num_t SAT_HI  =
        (wse_pkg::num_t'(1) <<< (wse_pkg::SAMPLE_BITS - 1)) - wse_pkg::num_t'(1);
    localparam wse_pkg::num_t SAT_LO  = -SAT_HI - wse_pkg::num_t'(1);

    wse_pkg::diff_t diff;
    wse_pkg::prod_t prod;
    wse_pkg::num_t  num;
    wse_pkg::num_t  rnd;

    // a*(L+R) + 2*(1-a)*C == a*(L+R-2C) + 2*C, one multiplier
    always_comb begin
        diff = wse_pkg::diff_t'(left) + wse_pkg::diff_t'(right)
             - (wse_pkg::diff_t'(centre) <<< 1);
        prod = wse_pkg::prod_t'($signed({1'b0, alpha_sq})) * wse_pkg::prod_t'(diff);
        num  = wse_pkg::num_t'(prod) + (wse_pkg::num_t'(centre) <<< wse_pkg::FRAC_ST);
        if (started) begin
            num = num - (wse_pkg::num_t'(prev) <<< wse_pkg::FRAC_LF);
            rnd = (num + HALF_LF) >>> wse_pkg::FRAC_LF;
        end else begin
            rnd = (num + HALF_ST) >>> wse_pkg::FRAC_ST;
        end
        priority if (rnd > SAT_HI) begin
            result = wse_pkg::sample_t'(SAT_HI);
        end else if (rnd < SAT_LO) begin
            result = wse_pkg::sample_t'(SAT_LO);
        end else begin
            result = wse_pkg::sample_t'(rnd);
        end
    end

endmodule

@@ rtl/core/wave_1d_stencil_step.sv @@
`timescale 1ns / 1ps

// 1d wave equation stepper on a periodic grid of up to 64 points. a load
// transfer (s_tuser = 0) writes one initial sample into the current row and
// produces no output; a step transfer (s_tuser = 1) advances one timestep
// and streams the new row out, one transfer per active point in index order
// with m_tlast on the final point. the first step after reset uses the start
// formula with zero initial velocity, every later step the leapfrog formula.
// samples are signed q2.13, saturated on output. the row lives in a ring of
// cells that rotates by one point per cycle, while the output register can
// take a result, through one shared update unit. after a step transfer there
// is a setup state, then the active points in index order, and s_tready
// rises again in the cycle after the last point; a low m_tready with a
// result waiting holds the ring in place. loads are accepted back to back
// while idle. configuration (alpha_sq in q0.16, active_points clamped to
// 3..64) is to be written through the cfg port only while the block is
// idle; the block itself does not enforce this.

module wave_1d_stencil_step (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wse_pkg::TDATA_W-1:0]     s_tdata,   // point_index, sample_in, zero pad
    input  logic [0:0]                      s_tuser,   // req_type

    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wse_pkg::TDATA_W-1:0]     m_tdata,   // out_index, out_value, zero pad
    output logic                            m_tlast,   // last_point

    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [0:0]                      cfg_addr,
    input  logic [wse_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int NP = wse_pkg::MAX_POINTS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    wse_pkg::alpha_t alpha_reg, alpha_next;
    wse_pkg::cnt_t   points_reg, points_next;
    wse_pkg::cnt_t   n_eff;

    assign cfg_ready = 1'b1;

    always_comb begin
        alpha_next  = alpha_reg;
        points_next = points_reg;
        if (cfg_valid) begin
            unique case (cfg_addr[0])
                wse_pkg::CFG_ALPHA_SQ:      alpha_next  = cfg_data[wse_pkg::ALPHA_W-1:0];
                wse_pkg::CFG_ACTIVE_POINTS: points_next = cfg_data[wse_pkg::CNT_W-1:0];
                default:                    alpha_next  = alpha_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg  <= wse_pkg::ALPHA_RESET;
            points_reg <= wse_pkg::POINTS_RESET;
        end else begin
            alpha_reg  <= alpha_next;
            points_reg <= points_next;
        end
    end

    // grid size in use, clamped to the legal range
    always_comb begin
        priority if (points_reg < wse_pkg::cnt_t'(wse_pkg::MIN_POINTS)) begin
            n_eff = wse_pkg::cnt_t'(wse_pkg::MIN_POINTS);
        end else if (points_reg > wse_pkg::cnt_t'(NP)) begin
            n_eff = wse_pkg::cnt_t'(NP);
        end else begin
            n_eff = points_reg;
        end
    end

    // ------------------------------------------------------------------
    // input unpacking
    // ------------------------------------------------------------------
    wse_pkg::idx_t    in_index;
    wse_pkg::sample_t in_sample;
    logic             in_xfer;
    logic             load_xfer;
    logic             step_xfer;

    assign in_index  = s_tdata[wse_pkg::IDX_W-1:0];
    assign in_sample = s_tdata[wse_pkg::IDX_W +: wse_pkg::SAMPLE_BITS];
    assign in_xfer   = s_tvalid && s_tready;
    assign load_xfer = in_xfer && (s_tuser[0] == wse_pkg::REQ_LOAD);
    assign step_xfer = in_xfer && (s_tuser[0] == wse_pkg::REQ_STEP);

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    wse_pkg::state_t  state_reg, state_next;
    wse_pkg::idx_t    cnt_reg, cnt_next;        // point being computed
    logic             started_reg, started_next;
    logic             out_valid_reg, out_valid_next;
    wse_pkg::idx_t    out_index_reg, out_index_next;
    wse_pkg::sample_t out_value_reg, out_value_next;
    logic             out_last_reg, out_last_next;
    wse_pkg::sample_t left_reg, left_next;      // old value of the point before
    wse_pkg::sample_t first_reg, first_next;    // old value of point 0, right of the last

    logic             advance;   // compute one point this cycle
    logic             last_pt;
    logic             prep;

    // ring taps: cell 0 is the head, cell 1 its right neighbor
    wse_pkg::cell_data_t cell_q   [NP];
    wse_pkg::sample_t    cell_tap [NP];
    wse_pkg::cell_ctrl_t cell_ctrl[NP];
    wse_pkg::cell_data_t tail_pair;
    wse_pkg::sample_t    tap_or;
    wse_pkg::sample_t    new_val;
    wse_pkg::sample_t    right_val;

    assign prep     = (state_reg == wse_pkg::ST_PREP);
    assign last_pt  = (wse_pkg::cnt_t'(cnt_reg) == n_eff - wse_pkg::cnt_t'(1));
    assign advance  = (state_reg == wse_pkg::ST_RUN) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == wse_pkg::ST_IDLE);

    // the right neighbor of the last point wraps to the saved old point 0
    assign right_val = last_pt ? first_reg : cell_q[1].cur;

    wse_update u_update (
        .alpha_sq (alpha_reg),
        .started  (started_reg),
        .left     (left_reg),
        .centre   (cell_q[0].cur),
        .right    (right_val),
        .prev     (cell_q[0].prev),
        .result   (new_val)
    );

    // the head leaves the ring and re-enters at the tail as (new, old)
    assign tail_pair.cur  = new_val;
    assign tail_pair.prev = cell_q[0].cur;

    // the old value of the last active point, picked by its tail flag
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < NP; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

    // ------------------------------------------------------------------
    // ring of cells
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NP; k++) begin : g_cell
        logic active;

        assign active = (wse_pkg::cnt_t'(k) < n_eff);

        assign cell_ctrl[k].load  = load_xfer && (in_index == wse_pkg::idx_t'(k));
        assign cell_ctrl[k].shift = advance && active;
        assign cell_ctrl[k].tail  = (wse_pkg::cnt_t'(k) == n_eff - wse_pkg::cnt_t'(1));
        // during a step, points outside the grid only age their prev entry
        assign cell_ctrl[k].age   = prep && !active;

        if (k == NP - 1) begin : g_end
            wse_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl[k]),
                .load_val (in_sample),
                .nb_in    (tail_pair),
                .tail_in  (tail_pair),
                .q        (cell_q[k]),
                .tap      (cell_tap[k])
            );
        end else begin : g_mid
            wse_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl[k]),
                .load_val (in_sample),
                .nb_in    (cell_q[k+1]),
                .tail_in  (tail_pair),
                .q        (cell_q[k]),
                .tap      (cell_tap[k])
            );
        end
    end

    // ------------------------------------------------------------------
    // sequencer: idle -> setup -> while the output register can take a result, one point per cycle
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        left_next      = left_reg;
        first_next     = first_reg;

        // output register empties on a transfer unless refilled below
        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            wse_pkg::ST_IDLE: begin
                if (step_xfer) begin
                    state_next = wse_pkg::ST_PREP;
                end
            end
            wse_pkg::ST_PREP: begin
                // left neighbor of point 0 is the last active point
                left_next  = tap_or;
                cnt_next   = '0;
                state_next = wse_pkg::ST_RUN;
            end
            wse_pkg::ST_RUN: begin
                if (advance) begin
                    out_valid_next = 1'b1;
                    out_index_next = cnt_reg;
                    out_value_next = new_val;
                    out_last_next  = last_pt;
                    left_next      = cell_q[0].cur;
                    if (cnt_reg == '0) begin
                        first_next = cell_q[0].cur;
                    end
                    cnt_next = cnt_reg + wse_pkg::idx_t'(1);
                    if (last_pt) begin
                        started_next = 1'b1;
                        state_next   = wse_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = wse_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wse_pkg::ST_IDLE;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        left_reg      <= left_next;
        first_reg     <= first_next;
    end

    // ------------------------------------------------------------------
    // result stream
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = wse_pkg::TDATA_W'({out_value_reg, out_index_reg});

endmodule
